// ===== rtl/core/annealing_two_opt_path_engine_unit_macros.svh =====
// Assertion macros for the annealing path engine checker.
// Depends on a clock i_clk and an active-low reset i_rst_n in scope.
`ifndef ANNEALING_TWO_OPT_PATH_ENGINE_UNIT_MACROS_SVH
`define ANNEALING_TWO_OPT_PATH_ENGINE_UNIT_MACROS_SVH

// same-cycle implication
`define ATPE_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("atpe assertion failed");

// next-cycle implication
`define ATPE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("atpe assertion failed");

`endif

// ===== rtl/core/atpe_pkg.sv =====
// Package of the annealing path engine: sizes, codes, state type, exp tables.
// No dependencies.
package atpe_pkg;

    localparam int MAX_CITIES = 256;
    localparam int DIST_W     = 32;
    localparam int CITY_W     = $clog2(MAX_CITIES);
    localparam int PATH_DEPTH = MAX_CITIES + 1;
    localparam int POS_W      = $clog2(PATH_DEPTH);
    localparam int STORE_SIZE = MAX_CITIES * MAX_CITIES;
    localparam int DADDR_W    = $clog2(STORE_SIZE);
    localparam int DPROD_W    = CITY_W + POS_W + 1;
    localparam int ENERGY_W   = 40;
    localparam int TEMP_W     = 32;
    localparam int COOL_W     = 24;
    localparam int Q_W        = 20;

    localparam logic [2:0] REQ_WDIST = 3'd0;
    localparam logic [2:0] REQ_WPATH = 3'd1;
    localparam logic [2:0] REQ_START = 3'd2;
    localparam logic [2:0] REQ_MOVE  = 3'd3;
    localparam logic [2:0] REQ_RPATH = 3'd4;

    localparam logic [1:0] CFG_CITY_COUNT = 2'd0;
    localparam logic [1:0] CFG_PATH_LEN   = 2'd1;
    localparam logic [1:0] CFG_START_TEMP = 2'd2;
    localparam logic [1:0] CFG_COOLING    = 2'd3;

    localparam logic [8:0]  RST_CITY_COUNT = 9'd256;
    localparam logic [8:0]  RST_PATH_LEN   = 9'd257;
    localparam logic [31:0] RST_START_TEMP = 32'd3276800;
    localparam logic [23:0] RST_COOLING    = 24'd16775540;

    typedef enum logic [4:0] {
        S_IDLE, S_DISPATCH, S_RW, S_SP, S_SC, S_SD, S_MP, S_MC, S_MD, S_ME,
        S_DL, S_DC, S_DIV, S_EX1, S_EX2, S_TC, S_TW, S_RA, S_RB, S_RC, S_RD,
        S_RESP
    } t_state;

    function automatic logic [16:0] e_int(input logic [3:0] i);
        logic [16:0] v;
        case (i)
            4'd0:    v = 17'd65536;
            4'd1:    v = 17'd24109;
            4'd2:    v = 17'd8869;
            4'd3:    v = 17'd3263;
            4'd4:    v = 17'd1200;
            4'd5:    v = 17'd442;
            4'd6:    v = 17'd162;
            4'd7:    v = 17'd60;
            4'd8:    v = 17'd22;
            4'd9:    v = 17'd8;
            4'd10:   v = 17'd3;
            4'd11:   v = 17'd1;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

    function automatic logic [16:0] e_six(input logic [3:0] k);
        logic [16:0] v;
        case (k)
            4'd0:    v = 17'd65536;
            4'd1:    v = 17'd61565;
            4'd2:    v = 17'd57835;
            4'd3:    v = 17'd54331;
            4'd4:    v = 17'd51039;
            4'd5:    v = 17'd47947;
            4'd6:    v = 17'd45042;
            4'd7:    v = 17'd42313;
            4'd8:    v = 17'd39750;
            4'd9:    v = 17'd37341;
            4'd10:   v = 17'd35079;
            4'd11:   v = 17'd32954;
            4'd12:   v = 17'd30957;
            4'd13:   v = 17'd29081;
            4'd14:   v = 17'd27319;
            default: v = 17'd25664;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/core/annealing_two_opt_path_engine_unit.sv =====
// Top level of the annealing 2-opt path engine: sequencer around two RAMs.
// Depends on atpe_pkg and atpe_ram.
//
// channel  direction  signals
// in       to block   i_in_valid / o_in_ready, request fields
// out      from block o_out_valid / i_out_ready, result fields
// cfg      to block   i_cfg_valid / o_cfg_ready, i_cfg_index, i_cfg_data
//
// Writes, unused codes and bad moves go from dispatch to the response; a valid path read first reads the path RAM.
// Start: one path read and one distance read per edge, through the path and distance RAM ports.
// Move: a reject without the exp test skips the serial divider; an accepted move adds
// cooling and a swap of each reversed pair (one path RAM port each way).
// Reset clears control and sets registers to defaults; RAMs hold no reset.
// A stalled result sits in the output register while the next item is taken.
module annealing_two_opt_path_engine_unit
    import atpe_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic [2:0]    i_req_type,
    input  logic [7:0]    i_row_city,
    input  logic [7:0]    i_col_city,
    input  logic [31:0]   i_distance_value,
    input  logic [8:0]    i_position,
    input  logic [7:0]    i_city_value,
    input  logic [8:0]    i_first_index,
    input  logic [8:0]    i_second_index,
    input  logic [15:0]   i_uniform_draw,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output logic          o_status,
    output logic          o_accepted,
    output logic [39:0]   o_energy,
    output logic [31:0]   o_temperature,
    output logic [7:0]    o_read_city,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [1:0]    i_cfg_index,
    input  logic [31:0]   i_cfg_data
);
    t_state r_state, n_state;

    logic [8:0]          r_cc, r_pl;
    logic [TEMP_W-1:0]   r_t0, r_temp;
    logic [COOL_W-1:0]   r_cool;
    logic [2:0]          r_req;
    logic [CITY_W-1:0]   r_row, r_col, r_cval, r_prev, r_vlo, r_rcity;
    logic [DIST_W-1:0]   r_dval;
    logic [8:0]          r_pos, r_a, r_b, r_idx, r_lo, r_hi;
    logic [15:0]         r_u;
    logic [ENERGY_W-1:0] r_energy, r_sum, r_ne;
    logic [1:0]          r_step;
    logic [CITY_W-1:0]   r_c [4];
    logic [DIST_W+1:0]   r_added, r_removed;
    logic                r_dok, r_status, r_acc;
    logic signed [DIST_W+2:0] r_delta;
    logic [TEMP_W+3:0]   r_t12;
    logic [TEMP_W-1:0]   r_rem;
    logic [Q_W-1:0]      r_dsh, r_q;
    logic [4:0]          r_cnt;
    logic [16:0]         r_p1;
    logic [TEMP_W+COOL_W-1:0] r_tprod;

    logic                r_o_valid, r_o_status, r_o_acc;
    logic [ENERGY_W-1:0] r_o_energy;
    logic [TEMP_W-1:0]   r_o_temp;
    logic [CITY_W-1:0]   r_o_rcity;

    logic [8:0]          w_len;
    logic                w_in_xfer, w_bad, w_load, w_pos_ok;
    logic [CITY_W-1:0]   w_drow, w_dcol;
    logic [DPROD_W-1:0]  w_dprod;
    logic                w_dok;
    logic                w_p_we, w_d_we;
    logic [POS_W-1:0]    w_p_waddr, w_p_raddr;
    logic [CITY_W-1:0]   w_p_wdata, w_p_rdata;
    logic [DIST_W-1:0]   w_d_rdata, w_dist;
    logic [ENERGY_W:0]   w_sum_n;
    logic [ENERGY_W-1:0] w_sum_sat;
    logic signed [DIST_W+2:0] w_delta;
    logic signed [ENERGY_W+1:0] w_ne;
    logic [TEMP_W:0]     w_trial;
    logic                w_ge;
    logic [33:0]         w_e1, w_p2;
    logic                w_take;
    logic [8:0]          w_a, w_b;

    assign w_len      = (r_pl > 9'(PATH_DEPTH)) ? 9'(PATH_DEPTH) : r_pl;
    assign w_in_xfer  = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_pos_ok   = ({1'b0, r_pos} < 10'(PATH_DEPTH));
    assign w_a = (i_first_index < i_second_index) ? i_first_index : i_second_index;
    assign w_b = (i_first_index < i_second_index) ? i_second_index : i_first_index;
    assign w_bad = (w_len < 9'd5) || (r_a == r_b) || (r_a == 9'd0)
                   || ({1'b0, r_b} > ({1'b0, w_len} - 10'd3));

    always_comb begin
        case (r_state)
            S_SC:    begin w_drow = r_prev; w_dcol = w_p_rdata; end
            S_MD: begin
                case (r_step)
                    2'd0:    begin w_drow = r_c[0]; w_dcol = r_c[2]; end
                    2'd1:    begin w_drow = r_c[1]; w_dcol = r_c[3]; end
                    2'd2:    begin w_drow = r_c[0]; w_dcol = r_c[1]; end
                    default: begin w_drow = r_c[2]; w_dcol = r_c[3]; end
                endcase
            end
            default: begin w_drow = r_row; w_dcol = r_col; end
        endcase
    end
    assign w_dprod = DPROD_W'(w_drow) * DPROD_W'(r_cc) + DPROD_W'(w_dcol);
    assign w_dok   = (w_dprod < DPROD_W'(STORE_SIZE));
    assign w_dist  = r_dok ? w_d_rdata : '0;

    assign w_d_we = (r_state == S_DISPATCH) && (r_req == REQ_WDIST) && w_dok;

    always_comb begin
        w_p_we    = 1'b0;
        w_p_waddr = r_pos;
        w_p_wdata = r_cval;
        case (r_state)
            S_DISPATCH: w_p_we = (r_req == REQ_WPATH) && w_pos_ok;
            S_RC: begin
                w_p_we = 1'b1; w_p_waddr = r_lo; w_p_wdata = w_p_rdata;
            end
            S_RD: begin
                w_p_we = 1'b1; w_p_waddr = r_hi; w_p_wdata = r_vlo;
            end
            default: w_p_we = 1'b0;
        endcase
    end

    always_comb begin
        case (r_state)
            S_SP: w_p_raddr = r_idx;
            S_MP: begin
                case (r_step)
                    2'd0:    w_p_raddr = r_a - 9'd1;
                    2'd1:    w_p_raddr = r_a;
                    2'd2:    w_p_raddr = r_b - 9'd1;
                    default: w_p_raddr = r_b;
                endcase
            end
            S_RA:    w_p_raddr = r_lo;
            S_RB:    w_p_raddr = r_hi;
            default: w_p_raddr = r_pos;
        endcase
    end

    atpe_ram #(.W(CITY_W), .D(PATH_DEPTH)) u_path_ram (
        .i_clk(i_clk), .i_we(w_p_we), .i_waddr(w_p_waddr), .i_wdata(w_p_wdata),
        .i_raddr(w_p_raddr), .o_rdata(w_p_rdata)
    );

    atpe_ram #(.W(DIST_W), .D(STORE_SIZE)) u_dist_ram (
        .i_clk(i_clk), .i_we(w_d_we), .i_waddr(w_dprod[DADDR_W-1:0]),
        .i_wdata(r_dval), .i_raddr(w_dprod[DADDR_W-1:0]), .o_rdata(w_d_rdata)
    );

    assign w_sum_n   = {1'b0, r_sum} + (ENERGY_W+1)'(w_dist);
    assign w_sum_sat = w_sum_n[ENERGY_W] ? '1 : w_sum_n[ENERGY_W-1:0];
    assign w_delta   = $signed({1'b0, r_added}) - $signed({1'b0, r_removed});
    assign w_ne      = $signed({2'b0, r_energy}) + (ENERGY_W+2)'(w_delta);
    assign w_trial   = {r_rem, r_dsh[Q_W-1]};
    assign w_ge      = (w_trial >= {1'b0, r_temp});
    assign w_e1      = 34'(e_int(r_q[19:16])) * 34'(e_six(r_q[15:12])) + 34'd32768;
    assign w_p2      = 34'(r_p1) * 34'(17'd65536 - 17'(r_q[11:0]));
    assign w_take    = ({2'b0, r_u} < w_p2[33:16]);
    assign w_load    = (r_state == S_RESP) && (!r_o_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:     if (w_in_xfer) n_state = S_DISPATCH;
            S_DISPATCH: begin
                case (r_req)
                    REQ_RPATH: n_state = w_pos_ok ? S_RW : S_RESP;
                    REQ_START: n_state = (w_len < 9'd2) ? S_RESP : S_SP;
                    REQ_MOVE:  n_state = w_bad ? S_RESP : S_MP;
                    default:   n_state = S_RESP;
                endcase
            end
            S_RW: n_state = S_RESP;
            S_SP: n_state = S_SC;
            S_SC: n_state = (r_idx == 9'd0) ? S_SP : S_SD;
            S_SD: n_state = (r_idx == w_len - 9'd1) ? S_RESP : S_SP;
            S_MP: n_state = S_MC;
            S_MC: n_state = (r_step == 2'd3) ? S_MD : S_MP;
            S_MD: n_state = S_ME;
            S_ME: n_state = (r_step == 2'd3) ? S_DL : S_MD;
            S_DL: n_state = S_DC;
            S_DC: begin
                if (r_delta <= 0) begin
                    n_state = S_TC;
                end else if (r_temp == '0 || 36'(r_delta[33:0]) >= r_t12) begin
                    n_state = S_RESP;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: if (r_cnt == 5'(Q_W - 1)) n_state = S_EX1;
            S_EX1: n_state = S_EX2;
            S_EX2: n_state = w_take ? S_TC : S_RESP;
            S_TC:  n_state = S_TW;
            S_TW:  n_state = ({1'b0, r_a} < {1'b0, r_b} - 10'd1) ? S_RA : S_RESP;
            S_RA:  n_state = S_RB;
            S_RB:  n_state = S_RC;
            S_RC:  n_state = S_RD;
            S_RD:  n_state = ({1'b0, r_lo} + 10'd2 < {1'b0, r_hi}) ? S_RA : S_RESP;
            S_RESP: if (w_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cc     <= RST_CITY_COUNT;
            r_pl     <= RST_PATH_LEN;
            r_t0     <= RST_START_TEMP;
            r_cool   <= RST_COOLING;
            r_energy <= '0;
            r_temp   <= RST_START_TEMP;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_CITY_COUNT: r_cc   <= i_cfg_data[8:0];
                    CFG_PATH_LEN:   r_pl   <= i_cfg_data[8:0];
                    CFG_START_TEMP: r_t0   <= i_cfg_data;
                    CFG_COOLING:    r_cool <= i_cfg_data[COOL_W-1:0];
                    default:        r_cc   <= r_cc;
                endcase
            end
            case (r_state)
                S_DISPATCH: if (r_req == REQ_START) begin
                    r_temp <= r_t0;
                    if (w_len < 9'd2) r_energy <= '0;
                end
                S_SD: if (r_idx == w_len - 9'd1) r_energy <= w_sum_sat;
                S_TC: r_energy <= r_ne;
                S_TW: r_temp <= r_tprod[TEMP_W+COOL_W-1:COOL_W];
                default: r_temp <= r_temp;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: if (w_in_xfer) begin
                r_req  <= i_req_type;
                r_row  <= i_row_city;
                r_col  <= i_col_city;
                r_dval <= i_distance_value;
                r_pos  <= i_position;
                r_cval <= i_city_value;
                r_a    <= w_a;
                r_b    <= w_b;
                r_u    <= i_uniform_draw;
                r_status <= 1'b0;
                r_acc    <= 1'b0;
                r_rcity  <= '0;
            end
            S_DISPATCH: begin
                r_sum     <= '0;
                r_idx     <= '0;
                r_step    <= '0;
                r_added   <= '0;
                r_removed <= '0;
                r_status  <= (r_req == REQ_MOVE) && w_bad;
            end
            S_RW: r_rcity <= w_p_rdata;
            S_SC: begin
                r_prev <= w_p_rdata;
                r_dok  <= w_dok;
                if (r_idx == 9'd0) r_idx <= 9'd1;
            end
            S_SD: begin
                r_sum <= w_sum_sat;
                r_idx <= r_idx + 9'd1;
            end
            S_MC: begin
                r_c[r_step] <= w_p_rdata;
                r_step      <= r_step + 2'd1;
            end
            S_MD: r_dok <= w_dok;
            S_ME: begin
                if (r_step[1]) begin
                    r_removed <= r_removed + (DIST_W+2)'(w_dist);
                end else begin
                    r_added <= r_added + (DIST_W+2)'(w_dist);
                end
                r_step <= r_step + 2'd1;
            end
            S_DL: begin
                r_delta <= w_delta;
                if (w_ne < 0) begin
                    r_ne <= '0;
                end else if (w_ne[ENERGY_W+1:ENERGY_W] != 2'b00) begin
                    r_ne <= '1;
                end else begin
                    r_ne <= w_ne[ENERGY_W-1:0];
                end
                r_t12 <= ({4'b0, r_temp} << 3) + ({4'b0, r_temp} << 2);
            end
            S_DC: begin
                r_rem <= TEMP_W'(r_delta[33:4]);
                r_dsh <= {r_delta[3:0], 16'b0};
                r_q   <= '0;
                r_cnt <= '0;
            end
            S_DIV: begin
                r_rem <= w_ge ? TEMP_W'(w_trial - {1'b0, r_temp}) : w_trial[TEMP_W-1:0];
                r_dsh <= r_dsh << 1;
                r_q   <= {r_q[Q_W-2:0], w_ge};
                r_cnt <= r_cnt + 5'd1;
            end
            S_EX1: r_p1 <= w_e1[32:16];
            S_TC: begin
                r_tprod <= (TEMP_W+COOL_W)'(r_temp) * (TEMP_W+COOL_W)'(r_cool);
                r_acc   <= 1'b1;
            end
            S_TW: begin
                r_lo <= r_a;
                r_hi <= r_b - 9'd1;
            end
            S_RB: r_vlo <= w_p_rdata;
            S_RD: begin
                r_lo <= r_lo + 9'd1;
                r_hi <= r_hi - 9'd1;
            end
            default: r_idx <= r_idx;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_load) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_o_status <= r_status;
            r_o_acc    <= r_acc;
            r_o_energy <= r_energy;
            r_o_temp   <= r_temp;
            r_o_rcity  <= r_rcity;
        end
    end

    assign o_out_valid   = r_o_valid;
    assign o_status      = r_o_status;
    assign o_accepted    = r_o_acc;
    assign o_energy      = r_o_energy;
    assign o_temperature = r_o_temp;
    assign o_read_city   = r_o_rcity;
endmodule

// ===== rtl/core/atpe_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module atpe_ram #(
    parameter int W = 8,
    parameter int D = 256
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/core/atpe_checker.sv =====
// Port-level checker for the annealing path engine, bound to the top level.
// Depends on annealing_two_opt_path_engine_unit_macros.svh.
`include "annealing_two_opt_path_engine_unit_macros.svh"
module atpe_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_status,
    input logic        o_accepted,
    input logic [39:0] o_energy,
    input logic [7:0]  o_read_city
);
    `ATPE_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid)
    `ATPE_ASSERT_NEXT(a_energy_hold, o_out_valid && !i_out_ready, $stable(o_energy))
    `ATPE_ASSERT_NOW(a_flag_excl, o_out_valid, !(o_status && o_accepted))
    `ATPE_ASSERT_NOW(a_move_no_city, o_out_valid && (o_status || o_accepted), o_read_city == 8'd0)
endmodule

bind annealing_two_opt_path_engine_unit atpe_checker u_atpe_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready), .o_status(o_status), .o_accepted(o_accepted),
    .o_energy(o_energy), .o_read_city(o_read_city)
);
